/* rtl/hpg_pkg.sv */
`timescale 1ns / 1ps

package hpg_pkg;

    localparam int BASE_W        = 8;
    localparam int COORD_W       = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int DIV_STEP_BITS = 4;   // quotient bits per divider cycle
    localparam int MUL_CHUNK_W   = 16;  // multiplicand slice per multiplier cycle

    typedef logic [BASE_W-1:0]           t_base;
    typedef logic signed [COORD_W-1:0]   t_coord;
    typedef logic [CFG_IDX_W-1:0]        t_cfg_idx;

    localparam t_base BASE_MIN = t_base'(2);

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_BASE_X = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_BASE_Y = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_MIN_X  = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_MIN_Y  = t_cfg_idx'(3);
    localparam t_cfg_idx CFG_MAX_X  = t_cfg_idx'(4);
    localparam t_cfg_idx CFG_MAX_Y  = t_cfg_idx'(5);

endpackage

/* rtl/hpg_div.sv */
`timescale 1ns / 1ps

// Long division by an 8-bit divisor, DIV_STEP_BITS quotient bits per cycle.
// Dividend is left aligned; quotient collects in the low bits.
module hpg_div import hpg_pkg::*; #(
    parameter int DW = 40,
    parameter int CW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [CW-1:0] i_steps,
    input  logic [DW-1:0] i_dividend,
    input  t_base         i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output t_base         o_rem
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_left;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_quo;
    t_base         r_rem;
    t_base         r_div;

    logic [DIV_STEP_BITS-1:0] q_bits;
    t_base                    n_rem;

    always_comb begin
        logic [BASE_W:0] trial;
        logic            ge;
        n_rem  = r_rem;
        q_bits = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++) begin
            trial = {n_rem, r_dvd[DW-1-i]};
            ge    = (trial >= {1'b0, r_div});
            q_bits[DIV_STEP_BITS-1-i] = ge;
            n_rem = ge ? BASE_W'(trial - {1'b0, r_div}) : trial[BASE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_left <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_left <= i_steps;
            end else if (r_busy) begin
                r_left <= r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= r_dvd << DIV_STEP_BITS;
            r_quo <= {r_quo[DW-DIV_STEP_BITS-1:0], q_bits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* rtl/hpg_mul.sv */
`timescale 1ns / 1ps

// offset = floor(frac * span / 2^FRAC_BITS), one 16 x 32 partial product per
// cycle, most significant slice first, product registered before the add.
module hpg_mul import hpg_pkg::*; #(
    parameter int FRAC_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  logic [COORD_W-1:0]   i_span,
    output logic                 o_done,
    output logic [COORD_W-1:0]   o_offset
);

    localparam int NCH = (FRAC_BITS + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int UW  = NCH * MUL_CHUNK_W;
    localparam int AW  = UW + COORD_W;
    localparam int PW  = MUL_CHUNK_W + COORD_W;
    localparam int KW  = $clog2(NCH + 1);

    logic               r_busy;
    logic [KW-1:0]      r_iss;
    logic               r_pv;
    logic [UW-1:0]      r_u;
    logic [COORD_W-1:0] r_span;
    logic [PW-1:0]      r_prod;
    logic [AW-1:0]      r_acc;

    logic [MUL_CHUNK_W-1:0] chunk;
    logic [PW-1:0]          prod;

    assign chunk = r_u[UW-1 -: MUL_CHUNK_W];
    assign prod  = PW'(chunk) * PW'(r_span);
    assign o_done = r_busy && (r_iss == '0) && !r_pv;
    assign o_offset = r_acc[FRAC_BITS +: COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iss  <= '0;
            r_pv   <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iss  <= KW'(NCH);
            r_pv   <= 1'b0;
        end else if (r_busy) begin
            r_pv <= (r_iss != '0);
            if (r_iss != '0) begin
                r_iss <= r_iss - KW'(1);
            end
            if (o_done) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u    <= UW'(i_frac);
            r_span <= i_span;
            r_acc  <= '0;
        end else begin
            if (r_iss != '0) begin
                r_prod <= prod;
                r_u    <= r_u << MUL_CHUNK_W;
            end
            if (r_pv) begin
                r_acc <= (r_acc << MUL_CHUNK_W) + AW'(r_prod);
            end
        end
    end

endmodule

/* rtl/halton_point_generator_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_stall     i_point_index
// out       source     o_out_valid / i_out_stall   o_point_x, o_point_y
// cfg       sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Per item and per axis: one divider run per digit of the index in that axis's base
// (no digits for index zero), one fraction step per digit, then the multiplier,
// or nothing for an empty box. The shared 4-bit-per-cycle divider does both the
// digit and the fraction steps.
// Reset (synchronous, active low) restores the configuration defaults and
// idles the sequencer. o_in_stall is high while an item is in work; one finished
// point waits in the output register while the next item is taken.
module halton_point_generator_core import hpg_pkg::*; #(
    parameter int INDEX_BITS = 20,
    parameter int FRAC_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [INDEX_BITS-1:0] i_point_index,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_coord                o_point_x,
    output t_coord                o_point_y,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  t_cfg_idx              i_cfg_index,
    input  logic [COORD_W-1:0]    i_cfg_data
);

    // Divider layout: index digits and fraction steps share one long divider.
    localparam int IDX_PAD   = ((INDEX_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                               * DIV_STEP_BITS;
    localparam int FR_W      = BASE_W + FRAC_BITS;
    localparam int FR_PAD    = ((FR_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS) * DIV_STEP_BITS;
    localparam int DIV_W     = (IDX_PAD > FR_PAD) ? IDX_PAD : FR_PAD;
    localparam int IDX_STEPS = IDX_PAD / DIV_STEP_BITS;
    localparam int FR_STEPS  = FR_PAD / DIV_STEP_BITS;
    localparam int DIV_CW    = $clog2(DIV_W / DIV_STEP_BITS + 1);
    localparam int CNT_W     = $clog2(INDEX_BITS + 1);
    localparam int DIG_AW    = $clog2(INDEX_BITS);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SETUP    = 4'd1;
    localparam logic [3:0] S_DIG_GO   = 4'd2;
    localparam logic [3:0] S_DIG_WAIT = 4'd3;
    localparam logic [3:0] S_FR_GO    = 4'd4;
    localparam logic [3:0] S_FR_WAIT  = 4'd5;
    localparam logic [3:0] S_SCALE    = 4'd6;
    localparam logic [3:0] S_MUL_WAIT = 4'd7;
    localparam logic [3:0] S_OUT      = 4'd8;

    // configuration
    t_base  r_base_x, r_base_y;
    t_coord r_min_x, r_min_y, r_max_x, r_max_y;

    // control
    logic [3:0]       r_state, n_state;
    logic             r_axis;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ov;

    // work registers
    logic [INDEX_BITS-1:0] r_index;
    logic [INDEX_BITS-1:0] r_num;
    logic [FRAC_BITS-1:0]  r_t;
    t_base                 r_base;
    t_base                 r_dig [INDEX_BITS];
    t_coord                r_px, r_py;
    t_coord                r_ox, r_oy;

    logic in_acc, out_acc, cfg_acc;
    logic div_start, div_done, mul_start, mul_done;
    logic [DIV_CW-1:0]  div_steps;
    logic [DIV_W-1:0]   div_dividend, div_quot;
    t_base              div_rem;
    logic [COORD_W-1:0] mul_off;

    t_base              cur_base_raw, eff_base;
    t_coord             cur_min, cur_max;
    logic               box_empty;
    logic [COORD_W-1:0] span;
    logic [CNT_W-1:0]   cnt_dec;
    logic [DIG_AW-1:0]  rd_idx;
    t_base              rd_digit;
    logic               coord_we;
    t_coord             coord_val;
    logic               last_quot_zero;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_point_x   = r_ox;
    assign o_point_y   = r_oy;

    // per-axis operands
    assign cur_base_raw = r_axis ? r_base_y : r_base_x;
    assign eff_base     = (cur_base_raw < BASE_MIN) ? BASE_MIN : cur_base_raw;
    assign cur_min      = r_axis ? r_min_y : r_min_x;
    assign cur_max      = r_axis ? r_max_y : r_max_x;
    assign box_empty    = (cur_max <= cur_min);
    assign span         = COORD_W'(cur_max - cur_min);   // below 2^32 when not empty

    // digits are replayed most significant first
    assign cnt_dec  = r_cnt - CNT_W'(1);
    assign rd_idx   = cnt_dec[DIG_AW-1:0];
    assign rd_digit = r_dig[rd_idx];

    assign last_quot_zero = (div_quot[INDEX_BITS-1:0] == '0);

    // divider command: digit extraction n / b, or fraction step (d*2^F + t) / b
    always_comb begin
        div_start    = 1'b0;
        div_steps    = DIV_CW'(IDX_STEPS);
        div_dividend = DIV_W'(r_num) << (DIV_W - IDX_PAD);
        if (r_state == S_DIG_GO) begin
            div_start = 1'b1;
        end else if (r_state == S_FR_GO) begin
            div_start    = 1'b1;
            div_steps    = DIV_CW'(FR_STEPS);
            div_dividend = DIV_W'({rd_digit, r_t}) << (DIV_W - FR_PAD);
        end
    end

    assign mul_start = (r_state == S_SCALE) && !box_empty;
    assign coord_we  = ((r_state == S_SCALE) && box_empty) ||
                       ((r_state == S_MUL_WAIT) && mul_done);
    assign coord_val = (r_state == S_SCALE) ? cur_min : t_coord'(cur_min + mul_off);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = (r_index == '0) ? S_SCALE : S_DIG_GO;
            end
            S_DIG_GO: begin
                n_state = S_DIG_WAIT;
            end
            S_DIG_WAIT: begin
                if (div_done) n_state = last_quot_zero ? S_FR_GO : S_DIG_GO;
            end
            S_FR_GO: begin
                n_state = S_FR_WAIT;
            end
            S_FR_WAIT: begin
                if (div_done) n_state = (r_cnt == '0) ? S_SCALE : S_FR_GO;
            end
            S_SCALE: begin
                // empty box finishes here, otherwise the multiplier runs
                if (box_empty) n_state = r_axis ? S_OUT : S_SETUP;
                else           n_state = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) n_state = r_axis ? S_OUT : S_SETUP;
            end
            S_OUT: begin
                if (!r_ov || !i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_axis   <= 1'b0;
            r_cnt    <= '0;
            r_ov     <= 1'b0;
            r_base_x <= t_base'(2);
            r_base_y <= t_base'(3);
            r_min_x  <= t_coord'(0);
            r_min_y  <= t_coord'(0);
            r_max_x  <= t_coord'(65536);
            r_max_y  <= t_coord'(65536);
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_axis <= 1'b0;
            end else if (coord_we) begin
                r_axis <= 1'b1;
            end
            if (r_state == S_SETUP) begin
                r_cnt <= '0;
            end else if ((r_state == S_DIG_WAIT) && div_done) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (r_state == S_FR_GO) begin
                r_cnt <= cnt_dec;
            end
            if ((r_state == S_OUT) && (n_state == S_IDLE)) begin
                r_ov <= 1'b1;
            end else if (out_acc) begin
                r_ov <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_BASE_X: r_base_x <= i_cfg_data[BASE_W-1:0];
                    CFG_BASE_Y: r_base_y <= i_cfg_data[BASE_W-1:0];
                    CFG_MIN_X:  r_min_x  <= t_coord'(i_cfg_data);
                    CFG_MIN_Y:  r_min_y  <= t_coord'(i_cfg_data);
                    CFG_MAX_X:  r_max_x  <= t_coord'(i_cfg_data);
                    CFG_MAX_Y:  r_max_y  <= t_coord'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_index <= i_point_index;
        end
        if (r_state == S_SETUP) begin
            r_base <= eff_base;
            r_num  <= r_index;
            r_t    <= '0;
        end
        if ((r_state == S_DIG_WAIT) && div_done) begin
            r_dig[r_cnt[DIG_AW-1:0]] <= div_rem;
            r_num <= div_quot[INDEX_BITS-1:0];
        end
        if ((r_state == S_FR_WAIT) && div_done) begin
            r_t <= div_quot[FRAC_BITS-1:0];
        end
        if (coord_we) begin
            if (r_axis) r_py <= coord_val;
            else        r_px <= coord_val;
        end
        if ((r_state == S_OUT) && (n_state == S_IDLE)) begin
            r_ox <= r_px;
            r_oy <= r_py;
        end
    end

    hpg_div #(
        .DW (DIV_W),
        .CW (DIV_CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (r_base),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    hpg_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_frac   (r_t),
        .i_span   (span),
        .o_done   (mul_done),
        .o_offset (mul_off)
    );

    // a pending point is never overwritten while the sink stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ov && i_out_stall) |=> (r_state == S_OUT))
        else $error("output register overwritten while stalled");

    // digit store never overflows
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(INDEX_BITS))
        else $error("digit count beyond index width");

    // divider completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIG_WAIT || r_state == S_FR_WAIT))
        else $error("divider result with no waiting step");

    // an accepted item always starts with axis x
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SETUP && !r_axis))
        else $error("accepted item did not enter setup");

endmodule

/* test/tb_halton_point_generator_core.sv */
`timescale 1ns / 1ps

module tb_halton_point_generator_core;
    import hpg_pkg::*;

    localparam int IDX_W        = 20;
    localparam int FRAC_W       = 32;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 250;
    localparam int TOTAL_ITEMS  = RAND_PHASES * PHASE_ITEMS + 25;
    // allow well over the worst-case time per item, plus the long hold
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = TOTAL_ITEMS * 3000 + 4 * HOLD_CYCLES + 100000;
    localparam int TAIL_CYCLES  = 800;

    typedef struct {
        t_coord x;
        t_coord y;
    } t_point;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [IDX_W-1:0]      i_point_index = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    t_coord                o_point_x;
    t_coord                o_point_y;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    t_cfg_idx              i_cfg_index   = CFG_BASE_X;
    logic [COORD_W-1:0]    i_cfg_data    = '0;

    halton_point_generator_core #(
        .INDEX_BITS (IDX_W),
        .FRAC_BITS  (FRAC_W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_point_index (i_point_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // local copy of the configuration registers, reset values
    t_base  cur_base_x = t_base'(2);
    t_base  cur_base_y = t_base'(3);
    t_coord cur_min_x  = 32'sd0;
    t_coord cur_min_y  = 32'sd0;
    t_coord cur_max_x  = 32'sd65536;
    t_coord cur_max_y  = 32'sd65536;

    logic [IDX_W-1:0] pending_indices[$];   // items not yet offered
    t_point           expected_points[$];   // points owed by the block
    int               err_count     = 0;
    int               cycle_count   = 0;
    int               taken_count   = 0;
    bit               idx_taken     = 1'b0; // input item accepted at last rising edge
    bit               calm          = 1'b0; // no idling on either side
    bit               pressure_done = 1'b0;

    // queue appends
    function automatic void add_pending(logic [IDX_W-1:0] v);
        pending_indices.insert(pending_indices.size(), v);
    endfunction

    function automatic void add_expected(t_point p);
        expected_points.insert(expected_points.size(), p);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor(radical inverse of n in base b, times 2^32); digits fed back
    // innermost first so each division floors the exact rational
    function automatic logic [63:0] radical_frac(logic [IDX_W-1:0] n, t_base b);
        logic [63:0] radix;
        logic [63:0] rest;
        logic [63:0] acc;
        logic [7:0]  digit[0:IDX_W];
        int          cnt;
        radix = (b < BASE_MIN) ? 64'd2 : 64'(b);   // bases 0 and 1 act as base 2
        rest  = 64'(n);
        acc   = 64'd0;
        cnt   = 0;
        while (rest > 0 && cnt < IDX_W + 1) begin
            digit[cnt] = 8'(rest % radix);
            rest       = rest / radix;
            cnt++;
        end
        while (cnt > 0) begin
            cnt--;
            acc = ((64'(digit[cnt]) << FRAC_W) + acc) / radix;
        end
        return acc;
    endfunction

    // min + floor(u * span / 2^32); empty or inverted box pins to min
    function automatic t_coord place_in_box(logic [63:0] u, t_coord lo, t_coord hi);
        logic [63:0] span;
        logic [63:0] acc;
        if (hi <= lo)
            return lo;
        span = 64'(longint'(hi) - longint'(lo));
        acc  = (u >> 16) * span + (((u & 64'hFFFF) * span) >> 16);
        return lo + t_coord'(acc >> (FRAC_W - 16));
    endfunction

    function automatic t_point predict_point(logic [IDX_W-1:0] n);
        t_point p;
        p.x = place_in_box(radical_frac(n, cur_base_x), cur_min_x, cur_max_x);
        p.y = place_in_box(radical_frac(n, cur_base_y), cur_min_y, cur_max_y);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------

    // random bit width from 1 to IDX_W, plus the occasional zero and all-ones index
    function automatic logic [IDX_W-1:0] rand_index();
        int          w;
        logic [31:0] mask;
        w = $urandom_range(1, IDX_W);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: begin
                mask = (32'd1 << w) - 32'd1;
                return IDX_W'($urandom & mask);
            end
        endcase
    endfunction

    function automatic t_base rand_base();
        case ($urandom_range(0, 4))
            0:       return t_base'($urandom_range(0, 255));
            1:       return t_base'($urandom_range(2, 7));
            2:       return t_base'($urandom_range(0, 1));
            3:       return t_base'(255);
            default: return t_base'($urandom_range(2, 20));
        endcase
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            default: return t_coord'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input driver: falling edge, holds a stalled item steady
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(negedge i_clk) begin
        logic             nxt_valid;
        logic [IDX_W-1:0] nxt_index;
        nxt_valid = i_in_valid;
        nxt_index = i_point_index;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_in_valid || idx_taken) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_indices.size() > 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 6) - 1;
                end else begin
                    nxt_valid = 1'b1;
                    nxt_index = pending_indices.pop_front();
                end
            end
        end
        i_in_valid    <= nxt_valid;
        i_point_index <= nxt_index;
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts plus one long hold-off so the block
    // backs up and stalls its input while the driver keeps offering
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_left  = 0;

    always @(negedge i_clk) begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            nxt_stall = 1'b1;
        end else if (!pressure_done && taken_count >= 100) begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES - 1;
            nxt_stall     = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt_stall = 1'b1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            nxt_stall  = 1'b1;
        end
        i_out_stall <= nxt_stall;
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge; check the result first, then log the new item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_point want;
        idx_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_points.size() == 0) begin
                    $error("point item with nothing expected: x %0d y %0d",
                           o_point_x, o_point_y);
                    err_count++;
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.x) begin
                        $error("point_x mismatch: expected %0d, actual %0d",
                               want.x, o_point_x);
                        err_count++;
                    end
                    if (o_point_y !== want.y) begin
                        $error("point_y mismatch: expected %0d, actual %0d",
                               want.y, o_point_y);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                idx_taken = 1'b1;
                taken_count++;
                add_expected(predict_point(i_point_index));
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes, only while the block is idle
    // ------------------------------------------------------------------
    task automatic cfg_write(t_cfg_idx idx, logic [COORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BASE_X: cur_base_x = data[BASE_W-1:0];
            CFG_BASE_Y: cur_base_y = data[BASE_W-1:0];
            CFG_MIN_X:  cur_min_x  = t_coord'(data);
            CFG_MIN_Y:  cur_min_y  = t_coord'(data);
            CFG_MAX_X:  cur_max_x  = t_coord'(data);
            CFG_MAX_Y:  cur_max_y  = t_coord'(data);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(t_base bx, t_base by, t_coord min_x, t_coord min_y,
                              t_coord max_x, t_coord max_y);
        cfg_write(CFG_BASE_X, COORD_W'(bx));
        cfg_write(CFG_BASE_Y, COORD_W'(by));
        cfg_write(CFG_MIN_X, min_x);
        cfg_write(CFG_MIN_Y, min_y);
        cfg_write(CFG_MAX_X, max_x);
        cfg_write(CFG_MAX_Y, max_y);
    endtask

    // wait until every queued item went in and every point came back
    task automatic drain();
        do @(posedge i_clk);
        while (pending_indices.size() > 0 || i_in_valid || expected_points.size() > 0);
        repeat (4) @(posedge i_clk);
    endtask

    // random box on one axis: mostly ordered, sometimes narrow, sometimes inverted
    task automatic rand_box(output t_coord lo, output t_coord hi);
        t_coord tmp;
        lo = rand_coord();
        hi = rand_coord();
        if ($urandom_range(0, 3) == 0)
            hi = lo + t_coord'($urandom_range(0, 262144));
        if ($urandom_range(0, 4) != 0 && hi <= lo) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
    endtask

    initial begin
        t_coord lx, hx, ly, hy;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: bases 2 and 3 on the unit square,
        // index zero, small indexes, single-bit and full-width patterns
        pending_indices = '{20'd0, 20'd1, 20'd2, 20'd3, 20'd4, 20'd7, 20'd8, 20'd9,
                            20'hFFFFF, 20'h80000, 20'h55555, 20'hAAAAA};
        drain();

        // bases 0 and 1 fall back to base 2; full-range x box, inverted y box
        set_config(t_base'(0), t_base'(1), 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh7FFF_FFFF, 32'sh8000_0000);
        pending_indices = '{20'd0, 20'd1, 20'd5, 20'hFFFFF};
        drain();

        // widest base, empty x box, symmetric y box around zero
        set_config(t_base'(255), t_base'(255), 32'sd100, -32'sd65536,
                   32'sd100, 32'sd65536);
        pending_indices = '{20'd0, 20'd254, 20'd255, 20'd65025, 20'hFFFFF};
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            rand_box(lx, hx);
            rand_box(ly, hy);
            set_config(rand_base(), rand_base(), lx, ly, hx, hy);
            // last phase runs without idling on either side
            if (ph == RAND_PHASES - 1)
                calm = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                add_pending(rand_index());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_points.size() > 0) begin
            $error("%0d expected points never arrived", expected_points.size());
            err_count++;
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/hpg_pkg.sv
rtl/hpg_div.sv
rtl/hpg_mul.sv
rtl/halton_point_generator_core.sv
test/tb_halton_point_generator_core.sv
